// ===== hdl/hdtd_pkg.sv =====
// Shared types and constants of the header/terminator deframer.
package hdtd_pkg;

  localparam int unsigned MaxFrame = 64;
  localparam int unsigned IdxW     = 6;
  localparam int unsigned CntW     = 7;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned NumBanks = 2;
  localparam int unsigned BankW    = 1;
  localparam int unsigned AddrW    = BankW + IdxW;
  localparam int unsigned OutDataW = 24;

  localparam logic [23:0] HdrPrefix = 24'h414135;
  localparam logic [7:0]  HdrFinal  = 8'h35;
  localparam logic [7:0]  TermCr    = 8'h0D;
  localparam logic [7:0]  LowerA    = 8'h61;
  localparam logic [7:0]  LowerZ    = 8'h7A;
  localparam logic [7:0]  CaseDelta = 8'h20;

  localparam logic [CntW-1:0] MaxCnt  = CntW'(MaxFrame);
  localparam logic [CntW-1:0] OverCnt = CntW'(MaxFrame + 1);

  // One completed frame waiting for delivery.
  typedef struct packed {
    logic [BankW-1:0] bank;
    logic [CntW-1:0]  len;
  } desc_t;

  // Write port into the payload store.
  typedef struct packed {
    logic             en;
    logic [AddrW-1:0] addr;
    logic [ByteW-1:0] data;
  } wr_t;

  function automatic logic [7:0] fold_upper(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= LowerA && c <= LowerZ) begin
      r = c - CaseDelta;
    end
    return r;
  endfunction

endpackage

// ===== hdl/header_terminator_deframer_top.sv =====
// Top level of the header/terminator deframer.
// Bytes are taken one per cycle; a transfer is stalled only while a payload is
// being captured and both payload banks still hold frames waiting for delivery.
// Each result is delivered by a store read (B_READ) followed by an output state
// (B_SHOW) that holds until the receiver takes it; an empty frame gives a single
// result, with has_data low, after its terminator.
// The two-bank payload store and the two-entry frame queue let capture of the
// next frame overlap delivery of the current one.
module header_terminator_deframer_top import hdtd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [7:0]          s_axis_tdata,   // [7:0] rx_byte
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,   // [7:0] data_byte, [13:8] byte_index,
                                              // [20:14] frame_length, [21] has_data
  output logic                m_axis_tlast    // last
);

  logic  push, pop, q_empty, q_full;
  desc_t push_desc, head;
  wr_t   wr;

  hdtd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid_i  (s_axis_tvalid),
    .s_tready_o  (s_axis_tready),
    .s_tdata_i   (s_axis_tdata),
    .q_full_i    (q_full),
    .push_o      (push),
    .push_desc_o (push_desc),
    .wr_o        (wr)
  );

  hdtd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_desc_i (push_desc),
    .pop_i       (pop),
    .head_o      (head),
    .empty_o     (q_empty),
    .full_o      (q_full)
  );

  hdtd_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_i       (wr),
    .head_i     (head),
    .q_empty_i  (q_empty),
    .pop_o      (pop),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_tdata_o  (m_axis_tdata),
    .m_tlast_o  (m_axis_tlast)
  );

endmodule

// ===== hdl/hdtd_front.sv =====
// Input side: case folding, header hunt and payload capture.
module hdtd_front import hdtd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_tvalid_i,
  output logic             s_tready_o,
  input  logic [7:0]       s_tdata_i,   // rx_byte
  input  logic             q_full_i,
  output logic             push_o,
  output desc_t            push_desc_o,
  output wr_t              wr_o
);

  logic [23:0]      window_q, window_d;
  logic             in_payload_q, in_payload_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [BankW-1:0] bank_q, bank_d;
  logic [7:0]       c;
  logic             acc;

  assign c          = fold_upper(s_tdata_i);
  // While in a payload the current bank may still be queued for delivery.
  assign s_tready_o = !in_payload_q || !q_full_i;
  assign acc        = s_tvalid_i && s_tready_o;

  always_comb begin
    window_d     = window_q;
    in_payload_d = in_payload_q;
    count_d      = count_q;
    bank_d       = bank_q;
    push_o       = 1'b0;
    push_desc_o  = '{bank: bank_q, len: count_q};
    wr_o         = '{en: 1'b0, addr: {bank_q, count_q[IdxW-1:0]}, data: c};
    if (acc) begin
      if (!in_payload_q) begin
        if (window_q == HdrPrefix && c == HdrFinal) begin
          in_payload_d = 1'b1;
          count_d      = '0;
          window_d     = '0;
        end else begin
          window_d = {window_q[15:0], c};
        end
      end else if (c != TermCr) begin
        if (count_q < MaxCnt) begin
          wr_o.en = 1'b1;
          count_d = count_q + 1'b1;
        end else begin
          count_d = OverCnt;
        end
      end else begin
        in_payload_d = 1'b0;
        window_d     = '0;
        count_d      = '0;
        if (count_q <= MaxCnt) begin
          push_o = 1'b1;
          bank_d = bank_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q     <= '0;
      in_payload_q <= 1'b0;
      count_q      <= '0;
      bank_q       <= '0;
    end else begin
      window_q     <= window_d;
      in_payload_q <= in_payload_d;
      count_q      <= count_d;
      bank_q       <= bank_d;
    end
  end

endmodule

// ===== hdl/hdtd_queue.sv =====
// Two-entry queue of completed frame descriptors.
module hdtd_queue import hdtd_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  desc_t push_desc_i,
  input  logic  pop_i,
  output desc_t head_o,
  output logic  empty_o,
  output logic  full_o
);

  desc_t      mem_q [NumBanks];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;

  assign head_o  = mem_q[rptr_q];
  assign empty_o = (cnt_q == 2'd0);
  assign full_o  = (cnt_q == 2'd2);

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= push_desc_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= ~wptr_q;
      end
      if (pop_i) begin
        rptr_q <= ~rptr_q;
      end
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

endmodule

// ===== hdl/hdtd_back.sv =====
// Output side: payload store and delivery of each frame as a run of results.
module hdtd_back import hdtd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  wr_t                 wr_i,
  input  desc_t               head_i,
  input  logic                q_empty_i,
  output logic                pop_o,
  output logic                m_tvalid_o,
  input  logic                m_tready_i,
  output logic [OutDataW-1:0] m_tdata_o,
  output logic                m_tlast_o
);

  typedef enum logic [1:0] {
    B_IDLE,
    B_READ,
    B_SHOW
  } state_e;

  state_e          state_q;
  logic [IdxW-1:0] idx_q;
  logic [7:0]      rdata_q;
  logic [7:0]      store_q [NumBanks * MaxFrame];
  logic            has_data;
  logic            is_last;
  logic [7:0]      data_byte;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      store_q[wr_i.addr] <= wr_i.data;
    end
    if (state_q == B_READ) begin
      rdata_q <= store_q[{head_i.bank, idx_q}];
    end
  end

  assign has_data   = (head_i.len != '0);
  assign is_last    = !has_data || ({1'b0, idx_q} + 1'b1 == head_i.len);
  assign data_byte  = has_data ? rdata_q : 8'h00;
  assign m_tvalid_o = (state_q == B_SHOW);
  assign m_tlast_o  = is_last;
  assign m_tdata_o  = {2'b00, has_data, head_i.len, idx_q, data_byte};
  assign pop_o      = m_tvalid_o && m_tready_i && is_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      idx_q   <= '0;
    end else begin
      case (state_q)
        B_IDLE: begin
          idx_q <= '0;
          if (!q_empty_i) begin
            state_q <= B_READ;
          end
        end
        B_READ: begin
          state_q <= B_SHOW;
        end
        B_SHOW: begin
          if (m_tready_i) begin
            if (is_last) begin
              state_q <= B_IDLE;
              idx_q   <= '0;
            end else begin
              state_q <= B_READ;
              idx_q   <= idx_q + 1'b1;
            end
          end
        end
        default: begin
          state_q <= B_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_show_needs_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o |-> !q_empty_i)
    else $error("result shown with no queued frame");
  a_pop_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> m_tlast_o && m_tready_i)
    else $error("frame released before its last result was taken");
  a_index_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != B_IDLE && has_data) |-> ({1'b0, idx_q} < head_i.len))
    else $error("byte index beyond frame length");
  a_no_write_to_read_bank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_i.en && state_q != B_IDLE) |-> (wr_i.addr[AddrW-1 -: BankW] != head_i.bank))
    else $error("payload write into the bank being delivered");
`endif

endmodule

// ===== bench/header_terminator_deframer_top_test.sv =====
// Self-checking stream testbench for the header/terminator deframer.
module header_terminator_deframer_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import hdtd_pkg::*;

  typedef struct packed {
    logic             last;
    logic             has_data;
    logic [CntW-1:0]  frame_length;
    logic [IdxW-1:0]  byte_index;
    logic [ByteW-1:0] data_byte;
  } deframed_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata = '0;   // [7:0] rx_byte
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;        // [7:0] data_byte, [13:8] byte_index,
                                            // [20:14] frame_length, [21] has_data
  logic                m_axis_tlast;

  header_terminator_deframer_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #2ns clk_i = ~clk_i;

  logic [7:0] rx_bytes_q[$];
  deframed_t  frame_results_q[$];
  int         fail_cnt = 0;

  // Deframer state as seen by the predictor.
  logic [23:0]      hunt_window = '0;
  logic             in_frame = 1'b0;
  logic [CntW-1:0]  frame_cnt = '0;
  logic [ByteW-1:0] frame_bytes [MaxFrame];

  function automatic logic [7:0] to_upper(input logic [7:0] c);
    return (c >= LowerA && c <= LowerZ) ? c - CaseDelta : c;
  endfunction

  task automatic deframe_byte(input logic [7:0] raw);
    logic [7:0] c;
    deframed_t  r;
    c = to_upper(raw);
    if (!in_frame) begin
      if (hunt_window == HdrPrefix && c == HdrFinal) begin
        in_frame    = 1'b1;
        frame_cnt   = '0;
        hunt_window = '0;
      end else begin
        hunt_window = {hunt_window[15:0], c};
      end
    end else if (c != TermCr) begin
      if (frame_cnt < MaxFrame) begin
        frame_bytes[frame_cnt[IdxW-1:0]] = c;
        frame_cnt = frame_cnt + 1'b1;
      end else begin
        frame_cnt = OverCnt;
      end
    end else begin
      in_frame    = 1'b0;
      hunt_window = '0;
      if (frame_cnt == 0) begin
        r = '0;
        r.last = 1'b1;
        frame_results_q.push_back(r);
      end else if (frame_cnt <= MaxFrame) begin
        for (int k = 0; k < frame_cnt; k++) begin
          r.data_byte    = frame_bytes[IdxW'(k)];
          r.byte_index   = IdxW'(k);
          r.frame_length = frame_cnt;
          r.has_data     = 1'b1;
          r.last         = (k + 1 == frame_cnt);
          frame_results_q.push_back(r);
        end
      end
      frame_cnt = '0;
    end
  endtask

  // Pushes the first n characters of the start sequence, letters in random case.
  task automatic push_header(input int n);
    logic [7:0] c;
    for (int i = 0; i < n; i++) begin
      c = (i < 2) ? HdrPrefix[23:16] : HdrFinal;
      if (i < 2 && $urandom_range(0, 1) == 1) c = c + CaseDelta;
      rx_bytes_q.push_back(c);
    end
  endtask

  function automatic logic [7:0] payload_char();
    logic [7:0] c;
    if ($urandom_range(0, 2) == 0) c = 8'($urandom_range(LowerA, LowerZ));
    else c = 8'($urandom_range(0, 255));
    if (c == TermCr) c = 8'h2E;
    return c;
  endfunction

  // Sender: bursts of random length separated by random gaps.
  int burst_left = 1;
  int gap_left   = 0;

  always @(posedge clk_i) begin : sender
    logic       nxt_valid;
    logic [7:0] nxt_data;
    nxt_valid = s_axis_tvalid;
    nxt_data  = s_axis_tdata;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        deframe_byte(s_axis_tdata);
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (rx_bytes_q.size() > 0) begin
          nxt_data  = rx_bytes_q.pop_front();
          nxt_valid = 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 48);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end
      end
    end
    s_axis_tvalid <= nxt_valid;
    s_axis_tdata  <= nxt_data;
  end

  // Receiver: periodic stall pattern whose period and duty change now and then.
  int stall_period = 1;
  int ready_duty   = 1;
  int stall_phase  = 0;
  int pattern_left = 0;

  always @(posedge clk_i) begin : receiver
    deframed_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (frame_results_q.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display("unexpected transfer: tdata=%h tlast=%b", m_axis_tdata, m_axis_tlast);
        end else begin
          want = frame_results_q.pop_front();
          if (m_axis_tdata[7:0] !== want.data_byte || m_axis_tdata[13:8] !== want.byte_index ||
              m_axis_tdata[20:14] !== want.frame_length ||
              m_axis_tdata[21] !== want.has_data || m_axis_tdata[23:22] !== 2'b00 ||
              m_axis_tlast !== want.last) begin
            fail_cnt++;
            if (fail_cnt <= 10)
              $display({"mismatch: expected data %h idx %0d len %0d has %b last %b, ",
                        "got data %h idx %0d len %0d has %b last %b pad %b"},
                       want.data_byte, want.byte_index, want.frame_length, want.has_data,
                       want.last, m_axis_tdata[7:0], m_axis_tdata[13:8],
                       m_axis_tdata[20:14], m_axis_tdata[21], m_axis_tlast,
                       m_axis_tdata[23:22]);
          end
        end
      end
      if (pattern_left == 0) begin
        pattern_left = $urandom_range(50, 250);
        stall_period = $urandom_range(1, 12);
        ready_duty   = ($urandom_range(0, 2) == 0) ? stall_period
                                                   : $urandom_range(1, stall_period);
        stall_phase  = 0;
      end
      pattern_left--;
      m_axis_tready <= (stall_phase < ready_duty);
      stall_phase = (stall_phase + 1) % stall_period;
    end
  end

  initial begin : run_ctl
    logic [7:0] directed_bytes [28];
    int         frame_no;
    int         frame_len;
    directed_bytes = '{
      8'h41, 8'h0D,                                  // carriage return while hunting
      8'h61, 8'h41, 8'h35, 8'h35,                    // start sequence in mixed case
      8'h00, 8'hFF, 8'h60, 8'h7B, 8'h7A, 8'h61, 8'h0D, // edges of the case fold
      8'h41, 8'h41, 8'h35, 8'h35, 8'h0D,             // empty frame
      8'h41, 8'h61, 8'h35, 8'h35,
      8'h41, 8'h41, 8'h35, 8'h35, 8'h0D,             // start sequence as payload data
      8'h35                                          // window was cleared by the frame end
    };
    foreach (directed_bytes[i]) rx_bytes_q.push_back(directed_bytes[i]);

    frame_no = 0;
    while (rx_bytes_q.size() < 330) begin
      repeat ($urandom_range(0, 3)) rx_bytes_q.push_back(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 9) == 0) begin
        push_header($urandom_range(1, 3));
        rx_bytes_q.push_back(8'($urandom_range(0, 255)));
      end else begin
        if (frame_no == 3) frame_len = MaxFrame;
        else if (frame_no == 6) frame_len = MaxFrame + 1 + $urandom_range(0, 4);
        else if ($urandom_range(0, 24) == 0) frame_len = $urandom_range(MaxFrame - 4,
                                                                        MaxFrame + 6);
        else frame_len = $urandom_range(0, 12);
        push_header(4);
        repeat (frame_len) rx_bytes_q.push_back(payload_char());
        rx_bytes_q.push_back(TermCr);
        frame_no++;
      end
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (rx_bytes_q.size() != 0 || s_axis_tvalid || frame_results_q.size() != 0)
      @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin : watchdog
    #400us;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/hdtd_pkg.sv
hdl/hdtd_front.sv
hdl/hdtd_queue.sv
hdl/hdtd_back.sv
hdl/header_terminator_deframer_top.sv
bench/header_terminator_deframer_top_test.sv
